// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the page frame replacement RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (reset is active low).
`define PFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pfr_pkg.sv =====
// Package for the page frame replacement block: widths, defaults, codes and
// shared types. No dependencies.
package pfr_pkg;

    localparam int MAX_FRAMES_DEF      = 64;
    localparam int PAGE_INDEX_BITS_DEF = 16;
    localparam int MAX_PAGE_BITS_DEF   = 12;

    localparam int PAGE_IN_W = 16;
    localparam int OFFSET_W  = 12;
    localparam int KIND_W    = 3;
    localparam int EVP_W     = 16;
    localparam int PA_W      = 18;
    localparam int FC_W      = 7;
    localparam int PSL_W     = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_POLICY      = 2'd0;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
    localparam logic [1:0] REG_PAGE_SIZE   = 2'd2;

    localparam logic            POLICY_RST = 1'b0;
    localparam logic [FC_W-1:0]  FC_RST     = 7'd64;
    localparam logic [PSL_W-1:0] PSL_RST    = 4'd12;

    localparam logic POLICY_FIFO  = 1'b0;
    localparam logic POLICY_CLOCK = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ_MISS     = 3'd0,
        KIND_WRITE_MISS    = 3'd1,
        KIND_FIRST_WRITE   = 3'd2,
        KIND_READ_HIT      = 3'd3,
        KIND_WRITE_HIT_MOD = 3'd4
    } t_kind;

    typedef struct packed {
        logic             policy;
        logic [FC_W-1:0]  frame_count;
        logic [PSL_W-1:0] page_size_log2;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic search;
        logic take_hit;
        logic take_fill;
        logic take_fifo;
        logic scan_init;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic room;
        logic clock;
        logic scan_found;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/pfr_if.sv =====
// Valid/ready channel interfaces for access items and result items.
// Depends on pfr_pkg.
interface pfr_in_if;
    logic                          valid;
    logic                          ready;
    logic [pfr_pkg::PAGE_IN_W-1:0] page_index;
    logic [pfr_pkg::OFFSET_W-1:0]  offset;
    logic                          is_write;

    modport source (output valid, output page_index, output offset, output is_write,
                    input ready);
    modport sink (input valid, input page_index, input offset, input is_write,
                  output ready);
endinterface

interface pfr_out_if;
    logic                       valid;
    logic                       ready;
    logic [pfr_pkg::KIND_W-1:0] fault_kind;
    logic                       evicted_valid;
    logic [pfr_pkg::EVP_W-1:0]  victim_page;
    logic                       dirty_evict;
    logic [pfr_pkg::PA_W-1:0]   phys_addr;
    logic                       allow_write;

    modport source (output valid, output fault_kind, output evicted_valid,
                    output victim_page, output dirty_evict, output phys_addr,
                    output allow_write, input ready);
    modport sink (input valid, input fault_kind, input evicted_valid,
                  input victim_page, input dirty_evict, input phys_addr,
                  input allow_write, output ready);
endinterface

// ===== hw/rtl/pfr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pfr_cfg.sv =====
// APB-style configuration registers: policy, frame count, page size.
// Depends on pfr_pkg.
module pfr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfr_pkg::APB_AW-1:0]  paddr,
    input  logic [pfr_pkg::APB_DW-1:0]  pwdata,
    output logic [pfr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output pfr_pkg::t_cfg               o_cfg
);

    logic                         r_policy;
    logic [pfr_pkg::FC_W-1:0]     r_frame_count;
    logic [pfr_pkg::PSL_W-1:0]    r_page_size_log2;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy         <= pfr_pkg::POLICY_RST;
            r_frame_count    <= pfr_pkg::FC_RST;
            r_page_size_log2 <= pfr_pkg::PSL_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                pfr_pkg::REG_POLICY:      r_policy         <= pwdata[0];
                pfr_pkg::REG_FRAME_COUNT: r_frame_count    <= pwdata[pfr_pkg::FC_W-1:0];
                pfr_pkg::REG_PAGE_SIZE:   r_page_size_log2 <= pwdata[pfr_pkg::PSL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pfr_pkg::REG_POLICY:      prdata = pfr_pkg::APB_DW'(r_policy);
            pfr_pkg::REG_FRAME_COUNT: prdata = pfr_pkg::APB_DW'(r_frame_count);
            pfr_pkg::REG_PAGE_SIZE:   prdata = pfr_pkg::APB_DW'(r_page_size_log2);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.policy         = r_policy;
    assign o_cfg.frame_count    = r_frame_count;
    assign o_cfg.page_size_log2 = r_page_size_log2;

endmodule

// ===== hw/rtl/pfr_ctrl.sv =====
// Sequencer for the replacement unit: search, fill or evict, commit.
// Depends on pfr_pkg; drives the datapath through t_cmd, reads t_sts.
module pfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfr_pkg::t_sts i_sts,
    output pfr_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_SCAN   = 6'b000100,
        S_VREAD  = 6'b001000,
        S_COMMIT = 6'b010000,
        S_SPARE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_COMMIT;
                end else if (i_sts.miss) begin
                    if (i_sts.room) begin
                        o_cmd.take_fill = 1'b1;
                        n_state         = S_COMMIT;
                    end else if (i_sts.clock) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.take_fifo = 1'b1;
                        n_state         = S_VREAD;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_found) begin
                    n_state = S_VREAD;
                end
            end
            S_VREAD: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pfr_dp.sv =====
// Datapath: page table RAM, frame marks, search and clock scan, result register.
// Depends on pfr_pkg, pfr_ram and assert_macros.svh.
`include "assert_macros.svh"
module pfr_dp #(
    parameter int MAX_FRAMES      = pfr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_INDEX_BITS = pfr_pkg::PAGE_INDEX_BITS_DEF,
    parameter int MAX_PAGE_BITS   = pfr_pkg::MAX_PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfr_pkg::t_cmd                 i_cmd,
    output pfr_pkg::t_sts                 o_sts,
    input  pfr_pkg::t_cfg                 i_cfg,
    input  logic [pfr_pkg::PAGE_IN_W-1:0] i_page_index,
    input  logic [pfr_pkg::OFFSET_W-1:0]  i_offset,
    input  logic                          i_is_write,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pfr_pkg::KIND_W-1:0]    o_fault_kind,
    output logic                          o_evicted_valid,
    output logic [pfr_pkg::EVP_W-1:0]     o_victim_page,
    output logic                          o_dirty_evict,
    output logic [pfr_pkg::PA_W-1:0]      o_phys_addr,
    output logic                          o_allow_write
);

    localparam int AW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int LW   = $clog2(3 * MAX_FRAMES + 3);
    localparam int PSW  = $clog2(MAX_PAGE_BITS + 1);
    localparam int SHW  = AW + MAX_PAGE_BITS + 1;
    localparam int SUMW = (SHW > pfr_pkg::PA_W) ? SHW : pfr_pkg::PA_W;

    logic [PAGE_INDEX_BITS-1:0]   r_page;
    logic [pfr_pkg::OFFSET_W-1:0] r_off;
    logic                         r_wr;

    logic [MAX_FRAMES-1:0] r_acc, r_mod, r_thd;
    logic [CW-1:0]         r_used;
    logic [AW-1:0]         r_hand;

    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] r_frame;
    logic          r_hit;
    logic          r_evict;
    logic [LW-1:0] r_cnt;

    logic                         r_ovalid;
    pfr_pkg::t_kind               r_kind;
    logic                         r_evv;
    logic [pfr_pkg::EVP_W-1:0]    r_evp;
    logic                         r_wb;
    logic [pfr_pkg::PA_W-1:0]     r_pa;
    logic                         r_aw;

    logic [PAGE_INDEX_BITS-1:0]   rdata;
    logic [AW-1:0]                raddr;
    logic                         ram_we;
    logic [CW-1:0]                eff;
    logic [LW-1:0]                limit;
    logic [PSW-1:0]               psl;
    logic [pfr_pkg::OFFSET_W-1:0] off_m;
    logic [SUMW-1:0]              pa_sum;
    logic [AW-1:0]                f_next;
    logic [AW-1:0]                hand_next;
    logic                         out_free;
    pfr_pkg::t_kind               kind;

    function automatic logic [AW-1:0] next_frame(input logic [AW-1:0] f,
                                                 input logic [CW-1:0] used);
        logic [CW:0] inc;
        inc = (CW + 1)'(f) + (CW + 1)'(1);
        if (inc >= (CW + 1)'(used)) begin
            return '0;
        end
        return inc[AW-1:0];
    endfunction

    assign raddr  = i_cmd.search ? r_idx[AW-1:0] : r_frame;
    assign ram_we = i_cmd.commit && !r_hit;

    pfr_ram #(
        .WIDTH (PAGE_INDEX_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_frame),
        .i_wdata (r_page),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (i_cfg.frame_count == '0) begin
            eff = CW'(1);
        end else if (32'(i_cfg.frame_count) > 32'(MAX_FRAMES)) begin
            eff = CW'(MAX_FRAMES);
        end else begin
            eff = CW'(i_cfg.frame_count);
        end
        if (32'(i_cfg.page_size_log2) > 32'(MAX_PAGE_BITS)) begin
            psl = PSW'(MAX_PAGE_BITS);
        end else begin
            psl = PSW'(i_cfg.page_size_log2);
        end
        for (int b = 0; b < pfr_pkg::OFFSET_W; b++) begin
            off_m[b] = r_off[b] && (b < int'(psl));
        end
    end

    assign limit     = LW'(r_used) * LW'(3) + LW'(2);
    assign pa_sum    = (SUMW'(r_frame) << psl) + SUMW'(off_m);
    assign f_next    = next_frame(r_frame, r_used);
    assign hand_next = next_frame(r_hand, r_used);
    assign out_free  = !r_ovalid || i_out_ready;

    always_comb begin
        if (r_hit) begin
            if (r_wr) begin
                kind = r_mod[r_frame] ? pfr_pkg::KIND_WRITE_HIT_MOD
                                      : pfr_pkg::KIND_FIRST_WRITE;
            end else begin
                kind = pfr_pkg::KIND_READ_HIT;
            end
        end else begin
            kind = r_wr ? pfr_pkg::KIND_WRITE_MISS : pfr_pkg::KIND_READ_MISS;
        end
    end

    assign o_sts.hit        = r_pend && (rdata == r_page);
    assign o_sts.miss       = !r_pend && (r_idx >= r_used);
    assign o_sts.room       = r_used < eff;
    assign o_sts.clock      = (i_cfg.policy == pfr_pkg::POLICY_CLOCK);
    assign o_sts.scan_found = (r_cnt >= limit) ||
                              (!r_acc[r_frame] && (!r_mod[r_frame] || r_thd[r_frame]));
    assign o_sts.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= PAGE_INDEX_BITS'(i_page_index);
            r_off  <= i_offset;
            r_wr   <= i_is_write;
        end
        if (i_cmd.search && (r_idx < r_used)) begin
            r_pidx <= r_idx[AW-1:0];
        end
        if (i_cmd.take_hit) begin
            r_frame <= r_pidx;
            r_hit   <= 1'b1;
            r_evict <= 1'b0;
        end else if (i_cmd.take_fill) begin
            r_frame <= r_used[AW-1:0];
            r_hit   <= 1'b0;
            r_evict <= 1'b0;
        end else if (i_cmd.take_fifo || i_cmd.scan_init) begin
            r_frame <= hand_next;
            r_hit   <= 1'b0;
            r_evict <= 1'b1;
        end else if (i_cmd.scan_step && !o_sts.scan_found) begin
            r_frame <= f_next;
        end
        if (i_cmd.scan_init) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_step && !o_sts.scan_found) begin
            r_cnt <= r_cnt + LW'(1);
        end
        if (i_cmd.commit) begin
            r_kind <= kind;
            r_evv  <= r_evict;
            r_evp  <= r_evict ? pfr_pkg::EVP_W'(rdata) : '0;
            r_wb   <= r_evict && r_mod[r_frame];
            r_pa   <= pa_sum[pfr_pkg::PA_W-1:0];
            r_aw   <= r_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_mod    <= '0;
            r_thd    <= '0;
            r_used   <= '0;
            r_hand   <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.search) begin
                if (r_idx < r_used) begin
                    r_idx  <= r_idx + CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (i_cmd.scan_step && !o_sts.scan_found) begin
                if (r_acc[r_frame]) begin
                    r_acc[r_frame] <= 1'b0;
                    r_thd[r_frame] <= 1'b0;
                end else begin
                    r_thd[r_frame] <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_acc[r_frame] <= 1'b1;
                r_thd[r_frame] <= 1'b0;
                if (r_hit) begin
                    r_mod[r_frame] <= r_mod[r_frame] | r_wr;
                end else begin
                    r_mod[r_frame] <= r_wr;
                    r_hand         <= r_frame;
                    if (!r_evict) begin
                        r_used <= r_used + CW'(1);
                    end
                end
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_fault_kind    = r_kind;
    assign o_evicted_valid = r_evv;
    assign o_victim_page   = r_evp;
    assign o_dirty_evict   = r_wb;
    assign o_phys_addr     = r_pa;
    assign o_allow_write   = r_aw;

    `PFR_ASSERT(a_hand_in_range, i_clk, i_rst_n, (r_used == '0) || (CW'(r_hand) < r_used), "hand outside resident frames")
    `PFR_ASSERT(a_commit_room, i_clk, i_rst_n, i_cmd.commit |-> out_free, "result committed over an untaken item")
    `PFR_ASSERT(a_evict_full, i_clk, i_rst_n, (i_cmd.take_fifo || i_cmd.scan_init) |-> (r_used != '0), "eviction with no resident frame")
    `PFR_ASSERT_ALWAYS(a_used_bound, i_clk, !i_rst_n || (32'(r_used) <= 32'(MAX_FRAMES)), "frame fill count beyond capacity")

endmodule

// ===== hw/rtl/page_frame_replacement.sv =====
// Top level of the page frame replacement unit.
// Depends on pfr_pkg, pfr_if, pfr_cfg, pfr_ctrl, pfr_dp (and pfr_ram below it).
//
// Usage: access items (page_index, offset, is_write) arrive on i_req; one
// result item per access leaves on o_rsp. Registers policy, frame_count and
// page_size_log2 sit at byte addresses 0, 4 and 8 of the APB port; write
// them only while the block is idle.
// Sequence: the resident frames are searched one RAM read a cycle. A hit
// or a fill then goes straight to the commit step; a FIFO eviction adds a
// victim read before it, and a clock eviction a mark scan and then that
// read. One item is in work at a time; i_req.ready is high only while the
// sequencer is idle, which it returns to once each result is registered,
// so a new item is not taken before the last result is registered.
// The result sits in an output register, so the next item is accepted while
// a result still waits; if o_rsp is stalled the following result is held
// in the sequencer until the register is taken.
// Reset (synchronous, active low) empties all frames, clears the marks and
// hand and restores the register defaults; no clearing pass is needed.
module page_frame_replacement #(
    parameter int MAX_FRAMES      = pfr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_INDEX_BITS = pfr_pkg::PAGE_INDEX_BITS_DEF,
    parameter int MAX_PAGE_BITS   = pfr_pkg::MAX_PAGE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pfr_in_if.sink                     i_req,
    pfr_out_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfr_pkg::APB_AW-1:0] paddr,
    input  logic [pfr_pkg::APB_DW-1:0] pwdata,
    output logic [pfr_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    pfr_pkg::t_cfg cfg;
    pfr_pkg::t_cmd cmd;
    pfr_pkg::t_sts sts;

    pfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfr_dp #(
        .MAX_FRAMES      (MAX_FRAMES),
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
        .MAX_PAGE_BITS   (MAX_PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg           (cfg),
        .i_page_index    (i_req.page_index),
        .i_offset        (i_req.offset),
        .i_is_write      (i_req.is_write),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_fault_kind    (o_rsp.fault_kind),
        .o_evicted_valid (o_rsp.evicted_valid),
        .o_victim_page   (o_rsp.victim_page),
        .o_dirty_evict   (o_rsp.dirty_evict),
        .o_phys_addr     (o_rsp.phys_addr),
        .o_allow_write   (o_rsp.allow_write)
    );

endmodule
